FILE: sv/planar_pose_realign_assert.svh
// ----------------------------------------------------------------------------
// planar pose realign assertion macros
// shared assertion wrappers clocked on clk, with and without reset disable
// ----------------------------------------------------------------------------
`ifndef PLANAR_POSE_REALIGN_ASSERT_SVH
`define PLANAR_POSE_REALIGN_ASSERT_SVH

// property checked outside reset
`define PPR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked on every edge, reset included
`define PPR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/ppr_pkg.sv
// ----------------------------------------------------------------------------
// ppr_pkg
// constants, register indexes and helper functions of the pose realign block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ppr_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int ATAN_NTAB  = 24;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROBOT_X   = 2'd0,
    CFG_ROBOT_Y   = 2'd1,
    CFG_ROBOT_YAW = 2'd2
  } cfg_idx_t;

  // gain-corrected 1.0 in q2.30
  localparam logic signed [33:0] CORDIC_ONE = 34'sd652032874;
  // 1.0 in q2.14
  localparam logic signed [15:0] Q14_ONE    = 16'sd16384;

  // arctangent of 2^-i as a 32-bit binary angle
  function automatic logic [31:0] atan_entry(input int unsigned i);
    logic [31:0] v;
    unique case (i)
      0:  v = 32'h20000000;
      1:  v = 32'h12E4051E;
      2:  v = 32'h09FB385B;
      3:  v = 32'h051111D4;
      4:  v = 32'h028B0D43;
      5:  v = 32'h0145D7E1;
      6:  v = 32'h00A2F61E;
      7:  v = 32'h00517C55;
      8:  v = 32'h0028BE53;
      9:  v = 32'h00145F2F;
      10: v = 32'h000A2F98;
      11: v = 32'h000517CC;
      12: v = 32'h00028BE6;
      13: v = 32'h000145F3;
      14: v = 32'h0000A2F9;
      15: v = 32'h0000517D;
      16: v = 32'h000028BE;
      17: v = 32'h0000145F;
      18: v = 32'h00000A2F;
      19: v = 32'h00000518;
      20: v = 32'h0000028C;
      21: v = 32'h00000146;
      22: v = 32'h000000A3;
      23: v = 32'h00000051;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

  // q2.30 to q2.14 with rounding and clamp to +-1.0
  function automatic logic signed [15:0] q14_round(input logic signed [33:0] v);
    logic signed [34:0] t;
    logic signed [18:0] r;
    logic signed [15:0] q;
    t = {v[33], v} + 35'sd32768;
    r = t[34:16];
    if (r > 19'sd16384)
      q = Q14_ONE;
    else if (r < -19'sd16384)
      q = -Q14_ONE;
    else
      q = r[15:0];
    return q;
  endfunction

endpackage

`default_nettype wire

FILE: sv/planar_pose_realign.sv
// ----------------------------------------------------------------------------
// planar_pose_realign
// realigns path waypoints onto the configured robot pose
// ----------------------------------------------------------------------------
// Each input word is one waypoint; in_tuser high marks the first waypoint of a
// path, whose position and quaternion yaw become the reference. Every waypoint
// is shifted by the reference, rotated by (robot_yaw - first_yaw), moved to
// (robot_x, robot_y) with saturation, and its yaw is rotated the same way and
// sent as a pure-yaw quaternion. The block takes one word per clock and gives one
// result word per clock while the output is not stalled; the pipeline is the
// unrolled vectoring CORDIC (one step a stage), the rotating CORDIC lanes and the
// multiply, sum and saturate stages. Stalls on the output back up through the
// pipeline one stage at a time, so empty stages still take new words. The user
// must ensure configuration is written only while the block holds no waypoints; the block does not enforce it.
`timescale 1ns / 1ps
`default_nettype none

module planar_pose_realign #(
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // config write port
  input  wire logic                            cfg_wr_en,
  input  wire logic [ppr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [ppr_pkg::CFG_DATA_W-1:0]  cfg_data,
  // waypoint input
  input  wire logic                            in_tvalid,
  output      logic                            in_tready,
  input  wire logic [127:0]                    in_tdata,  // pos_x, pos_y, quat_x, quat_y, quat_z, quat_w
  input  wire logic                            in_tuser,  // first_point
  // realigned output
  output      logic                            out_tvalid,
  input  wire logic                            out_tready,
  output      logic [95:0]                     out_tdata, // out_x, out_y, out_qz, out_qw
  output      logic                            out_tuser  // saturated
);
  import ppr_pkg::*;

  localparam int N     = CORDIC_STEPS;
  localparam int VW    = 37;
  localparam int SR    = N + 2;
  localparam int ST    = 2 * N + 3;
  localparam int SM1   = 2 * N + 4;
  localparam int SM2   = 2 * N + 5;
  localparam int SO    = 2 * N + 6;
  localparam int NSTG  = 2 * N + 7;

  // config registers
  logic signed [31:0] robot_x_r, robot_y_r;
  logic        [15:0] robot_yaw_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      robot_x_r   <= '0;
      robot_y_r   <= '0;
      robot_yaw_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ROBOT_X:   robot_x_r   <= cfg_data;
        CFG_ROBOT_Y:   robot_y_r   <= cfg_data;
        CFG_ROBOT_YAW: robot_yaw_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // pipeline valid bits and per-stage advance
  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] vld_nxt;
  logic [NSTG:0]   adv;

  assign adv[NSTG] = out_tready;
  genvar k;
  generate
    for (k = 0; k < NSTG; k++) begin : g_adv
      assign adv[k] = !vld_r[k] || adv[k+1];
    end
  endgenerate

  assign vld_nxt   = {vld_r[NSTG-2:0], in_tvalid};
  assign in_tready = adv[0];

  always_ff @(posedge clk) begin
    if (!rst_n)
      vld_r <= '0;
    else
      vld_r <= (vld_nxt & adv[NSTG-1:0]) | (vld_r & ~adv[NSTG-1:0]);
  end

  // stage 0: quaternion products
  logic signed [15:0] qx, qy, qz, qw;
  logic               f0_r;
  logic signed [31:0] px0_r, py0_r, wz_r, xy_r, yy_r, zz_r;

  assign qx = in_tdata[79:64];
  assign qy = in_tdata[95:80];
  assign qz = in_tdata[111:96];
  assign qw = in_tdata[127:112];

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      f0_r  <= in_tuser;
      px0_r <= in_tdata[31:0];
      py0_r <= in_tdata[63:32];
      wz_r  <= qw * qz;
      xy_r  <= qx * qy;
      yy_r  <= qy * qy;
      zz_r  <= qz * qz;
    end
  end

  // vectoring cordic arrays, entry 0 written by stage 1
  logic signed [VW-1:0] vx_r  [0:N];
  logic signed [VW-1:0] vy_r  [0:N];
  logic        [31:0]   va_r  [0:N];
  logic                 vz_r  [0:N];
  logic                 vf_r  [0:N];
  logic signed [31:0]   vpx_r [0:N];
  logic signed [31:0]   vpy_r [0:N];

  // stage 1: sine and cosine terms of yaw, turn into right half plane
  logic signed [32:0] sum_s, sum_c;
  logic signed [33:0] s34, c34;

  always_comb begin
    sum_s = {wz_r[31], wz_r} + {xy_r[31], xy_r};
    sum_c = {yy_r[31], yy_r} + {zz_r[31], zz_r};
    s34   = {sum_s, 1'b0};
    c34   = 34'sd268435456 - {sum_c, 1'b0};
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      vf_r[0]  <= f0_r;
      vpx_r[0] <= px0_r;
      vpy_r[0] <= py0_r;
      vz_r[0]  <= (s34 == '0) && (c34 == '0);
      if (c34 < 0) begin
        vx_r[0] <= -{{(VW-34){c34[33]}}, c34};
        vy_r[0] <= -{{(VW-34){s34[33]}}, s34};
        va_r[0] <= 32'h80000000;
      end else begin
        vx_r[0] <= {{(VW-34){c34[33]}}, c34};
        vy_r[0] <= {{(VW-34){s34[33]}}, s34};
        va_r[0] <= '0;
      end
    end
  end

  // vectoring steps, one per stage
  genvar i;
  generate
    for (i = 0; i < N; i++) begin : g_vec
      localparam logic [31:0] ATN = atan_entry(i);
      always_ff @(posedge clk) begin
        if (adv[2+i]) begin
          vf_r[i+1]  <= vf_r[i];
          vpx_r[i+1] <= vpx_r[i];
          vpy_r[i+1] <= vpy_r[i];
          vz_r[i+1]  <= vz_r[i];
          if (vy_r[i] > 0) begin
            vx_r[i+1] <= vx_r[i] + (vy_r[i] >>> i);
            vy_r[i+1] <= vy_r[i] - (vx_r[i] >>> i);
            va_r[i+1] <= va_r[i] + ATN;
          end else begin
            vx_r[i+1] <= vx_r[i] - (vy_r[i] >>> i);
            vy_r[i+1] <= vy_r[i] + (vx_r[i] >>> i);
            va_r[i+1] <= va_r[i] - ATN;
          end
        end
      end
    end
  endgenerate

  // rotating cordic arrays, lane 0 for the rotation, lane 1 for half new yaw
  logic signed [33:0] cx_r  [0:N][0:1];
  logic signed [33:0] cy_r  [0:N][0:1];
  logic signed [33:0] cz_r  [0:N][0:1];
  logic               cfl_r [0:N][0:1];
  logic               sf_r  [0:N];
  logic signed [32:0] sdx_r [0:N];
  logic signed [32:0] sdy_r [0:N];

  // stage r: yaw, rotation angle and reference state
  logic        [15:0]   rot_angle_r;
  logic signed [31:0]   ref_x_r, ref_y_r;
  logic        [31:0]   yaw_t;
  logic        [15:0]   yaw16, rot_use, ny16;
  logic signed [31:0]   refx_use, refy_use;
  logic        [31:0]   ang [0:1];
  logic        [31:0]   angf [0:1];
  logic                 flp [0:1];
  logic                 ld_ref;

  always_comb begin
    yaw_t    = va_r[N] + 32'h00008000;
    yaw16    = vz_r[N] ? 16'h0 : yaw_t[31:16];
    rot_use  = vf_r[N] ? (robot_yaw_r - yaw16) : rot_angle_r;
    refx_use = vf_r[N] ? vpx_r[N] : ref_x_r;
    refy_use = vf_r[N] ? vpy_r[N] : ref_y_r;
    ny16     = yaw16 + rot_use;
    ang[0]   = {rot_use, 16'h0};
    ang[1]   = {ny16[15], ny16, 15'h0};
    for (int l = 0; l < 2; l++) begin
      flp[l]  = ang[l][31] ^ ang[l][30];
      angf[l] = flp[l] ? (ang[l] ^ 32'h80000000) : ang[l];
    end
    ld_ref   = adv[SR] && vld_nxt[SR] && vf_r[N];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_angle_r <= '0;
      ref_x_r     <= '0;
      ref_y_r     <= '0;
    end else if (ld_ref) begin
      rot_angle_r <= rot_use;
      ref_x_r     <= vpx_r[N];
      ref_y_r     <= vpy_r[N];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[SR]) begin
      sf_r[0]  <= vf_r[N];
      sdx_r[0] <= {vpx_r[N][31], vpx_r[N]} - {refx_use[31], refx_use};
      sdy_r[0] <= {vpy_r[N][31], vpy_r[N]} - {refy_use[31], refy_use};
      for (int l = 0; l < 2; l++) begin
        cx_r[0][l]  <= CORDIC_ONE;
        cy_r[0][l]  <= '0;
        cz_r[0][l]  <= {{2{angf[l][31]}}, angf[l]};
        cfl_r[0][l] <= flp[l];
      end
    end
  end

  // rotating steps, one per stage, both lanes side by side
  generate
    for (i = 0; i < N; i++) begin : g_rot
      localparam logic [31:0] ATN = atan_entry(i);
      always_ff @(posedge clk) begin
        if (adv[SR+1+i]) begin
          sf_r[i+1]  <= sf_r[i];
          sdx_r[i+1] <= sdx_r[i];
          sdy_r[i+1] <= sdy_r[i];
          for (int l = 0; l < 2; l++) begin
            cfl_r[i+1][l] <= cfl_r[i][l];
            if (cz_r[i][l] >= 0) begin
              cx_r[i+1][l] <= cx_r[i][l] - (cy_r[i][l] >>> i);
              cy_r[i+1][l] <= cy_r[i][l] + (cx_r[i][l] >>> i);
              cz_r[i+1][l] <= cz_r[i][l] - $signed({2'b00, ATN});
            end else begin
              cx_r[i+1][l] <= cx_r[i][l] + (cy_r[i][l] >>> i);
              cy_r[i+1][l] <= cy_r[i][l] - (cx_r[i][l] >>> i);
              cz_r[i+1][l] <= cz_r[i][l] + $signed({2'b00, ATN});
            end
          end
        end
      end
    end
  endgenerate

  // stage t: undo half-plane turn, round to q2.14, rotation cos and sin state
  logic signed [15:0] rot_cos_r, rot_sin_r;
  logic signed [15:0] qc [0:1];
  logic signed [15:0] qs [0:1];
  logic signed [15:0] cos_use, sin_use;
  logic signed [33:0] xf, yf;
  logic               ld_rot;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      xf    = cfl_r[N][l] ? -cx_r[N][l] : cx_r[N][l];
      yf    = cfl_r[N][l] ? -cy_r[N][l] : cy_r[N][l];
      qc[l] = q14_round(xf);
      qs[l] = q14_round(yf);
    end
    cos_use = sf_r[N] ? qc[0] : rot_cos_r;
    sin_use = sf_r[N] ? qs[0] : rot_sin_r;
    ld_rot  = adv[ST] && vld_nxt[ST] && sf_r[N];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_cos_r <= Q14_ONE;
      rot_sin_r <= '0;
    end else if (ld_rot) begin
      rot_cos_r <= qc[0];
      rot_sin_r <= qs[0];
    end
  end

  logic signed [15:0] tcos_r, tsin_r, tqz_r, tqw_r;
  logic signed [32:0] tdx_r, tdy_r;

  always_ff @(posedge clk) begin
    if (adv[ST]) begin
      tcos_r <= cos_use;
      tsin_r <= sin_use;
      tqw_r  <= qc[1];
      tqz_r  <= qs[1];
      tdx_r  <= sdx_r[N];
      tdy_r  <= sdy_r[N];
    end
  end

  // stage m1: rotation products
  logic signed [48:0] pcx_r, psy_r, psx_r, pcy_r;
  logic signed [15:0] mqz_r, mqw_r;

  always_ff @(posedge clk) begin
    if (adv[SM1]) begin
      pcx_r <= tcos_r * tdx_r;
      psy_r <= tsin_r * tdy_r;
      psx_r <= tsin_r * tdx_r;
      pcy_r <= tcos_r * tdy_r;
      mqz_r <= tqz_r;
      mqw_r <= tqw_r;
    end
  end

  // stage m2: sum and round back to q16.16
  logic signed [49:0] sum_x, sum_y;
  logic signed [35:0] sx_r, sy_r;
  logic signed [15:0] nqz_r, nqw_r;

  always_comb begin
    sum_x = {pcx_r[48], pcx_r} - {psy_r[48], psy_r} + 50'sd8192;
    sum_y = {psx_r[48], psx_r} + {pcy_r[48], pcy_r} + 50'sd8192;
  end

  always_ff @(posedge clk) begin
    if (adv[SM2]) begin
      sx_r  <= sum_x[49:14];
      sy_r  <= sum_y[49:14];
      nqz_r <= mqz_r;
      nqw_r <= mqw_r;
    end
  end

  // output stage: add robot position and saturate
  logic signed [36:0] ax, ay;
  logic signed [31:0] satx, saty;
  logic               ovx, ovy;
  logic signed [31:0] ox_r, oy_r;
  logic signed [15:0] oqz_r, oqw_r;
  logic               osat_r;

  always_comb begin
    ax   = {{5{robot_x_r[31]}}, robot_x_r} + {sx_r[35], sx_r};
    ay   = {{5{robot_y_r[31]}}, robot_y_r} + {sy_r[35], sy_r};
    ovx  = (ax[36:31] != '0) && (ax[36:31] != '1);
    ovy  = (ay[36:31] != '0) && (ay[36:31] != '1);
    satx = ovx ? (ax[36] ? 32'sh80000000 : 32'sh7FFFFFFF) : ax[31:0];
    saty = ovy ? (ay[36] ? 32'sh80000000 : 32'sh7FFFFFFF) : ay[31:0];
  end

  always_ff @(posedge clk) begin
    if (adv[SO]) begin
      ox_r   <= satx;
      oy_r   <= saty;
      oqz_r  <= nqz_r;
      oqw_r  <= nqw_r;
      osat_r <= ovx || ovy;
    end
  end

  assign out_tvalid = vld_r[SO];
  assign out_tdata  = {oqw_r, oqz_r, oy_r, ox_r};
  assign out_tuser  = osat_r;

  // checks
  `include "planar_pose_realign_assert.svh"

  `PPR_ASSERT_ALWAYS(a_rst_empty, !rst_n |=> (vld_r == '0), "pipeline not empty after reset")
  `PPR_ASSERT(a_accept_lands, (in_tvalid && in_tready) |=> vld_r[0], "accepted word lost at entry")
  `PPR_ASSERT(a_out_hold, (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tuser)), "output word changed while stalled")
  `PPR_ASSERT(a_cos_range, (rot_cos_r <= Q14_ONE) && (rot_cos_r >= -Q14_ONE), "rotation cosine out of range")

endmodule

`default_nettype wire
